>>> rtl/core/srchk_pkg.sv
// Shared types and constants for the segment reassembly checker.
// Used by every module in rtl/core; depends on nothing else.
package srchk_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] CAPACITY_RESET = 16'd4096;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_APPEND,
		CMD_CLEAR,
		CMD_NONE
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] seq;
		logic [7:0]  kind;
		logic [15:0] file;
		logic [15:0] index;
		logic [15:0] total;
		logic [15:0] length;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/core/srchk_front.sv
// Front stage: takes header words, decodes the operation and pushes them to the queue.
// Depends on srchk_pkg.
module srchk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        packet_sequence,
	input  logic [7:0]         packet_kind,
	input  logic [15:0]        file_number,
	input  logic [15:0]        segment_index,
	input  logic [15:0]        segment_total,
	input  logic [15:0]        payload_length,
	input  srchk_pkg::q_status_t q_stat,
	output logic               push,
	output srchk_pkg::item_t   push_item
);
	import srchk_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	cmd_t  cmd;
	logic  take;

	always_comb begin
		unique case (op)
			OP_START:  cmd = CMD_START;
			OP_APPEND: cmd = CMD_APPEND;
			OP_CLEAR:  cmd = CMD_CLEAR;
			OP_UNUSED: cmd = CMD_NONE;
			default:   cmd = CMD_NONE;
		endcase
	end

	assign push     = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;
	assign take     = in_valid && in_ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd    <= cmd;
			item_s1.seq    <= packet_sequence;
			item_s1.kind   <= packet_kind;
			item_s1.file   <= file_number;
			item_s1.index  <= segment_index;
			item_s1.total  <= segment_total;
			item_s1.length <= payload_length;
		end
	end

endmodule

>>> rtl/core/srchk_queue.sv
// Short queue of decoded header words between the front and back stages.
// Depends on srchk_pkg.
module srchk_queue #(
	parameter int QUEUE_DEPTH = srchk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srchk_pkg::item_t     push_item,
	input  logic                 pop,
	output srchk_pkg::item_t     pop_item,
	output srchk_pkg::q_status_t q_stat
);
	import srchk_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	item_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/core/srchk_back.sv
// Back stage: sequence tracking, header check, fill accounting and the result register.
// Depends on srchk_pkg.
module srchk_back #(
	parameter int COUNT_WIDTH = srchk_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          capacity,
	input  srchk_pkg::q_status_t q_stat,
	input  srchk_pkg::item_t     item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [31:0]          missed_count,
	output logic [31:0]          error_count,
	output logic [15:0]          fill_level
);
	import srchk_pkg::*;

	logic                   out_valid_q;
	logic                   accepted_q;
	logic                   first_q;
	logic [31:0]            expected_q;
	logic [COUNT_WIDTH-1:0] missed_q;
	logic [COUNT_WIDTH-1:0] error_q;
	logic                   ok_q;
	logic [7:0]             kind_q;
	logic [15:0]            file_q;
	logic [15:0]            total_q;
	logic [15:0]            seg_q;
	logic [15:0]            bytes_q;

	logic [31:0]               exp_eff;
	logic [31:0]               gap;
	logic                      fwd;
	logic [COUNT_WIDTH+31:0]   gap_ext;
	logic [COUNT_WIDTH-1:0]    missed_add;
	logic [15:0]               seg_next;
	logic                      match;
	logic                      ok_next;
	logic [16:0]               sum;
	logic                      fits;
	logic [COUNT_WIDTH+31:0]   missed_ext;
	logic [COUNT_WIDTH+31:0]   error_ext;

	assign pop = !q_stat.empty && (!out_valid_q || out_ready);

	assign exp_eff    = first_q ? item.seq : expected_q;
	assign gap        = item.seq - exp_eff;
	assign fwd        = item.seq > exp_eff;
	assign gap_ext    = {{COUNT_WIDTH{1'b0}}, gap};
	assign missed_add = missed_q + gap_ext[COUNT_WIDTH-1:0];
	assign seg_next   = seg_q + 16'd1;
	assign match      = (item.kind == kind_q) && (item.file == file_q) &&
	                    (item.index == seg_next) && (item.total == total_q);
	assign ok_next    = ok_q && match;
	assign sum        = {1'b0, bytes_q} + {1'b0, item.length};
	assign fits       = sum <= {1'b0, capacity};

	assign missed_ext   = {32'd0, missed_q};
	assign error_ext    = {32'd0, error_q};
	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign missed_count = missed_ext[31:0];
	assign error_count  = error_ext[31:0];
	assign fill_level   = bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			first_q     <= 1'b1;
			expected_q  <= '0;
			missed_q    <= '0;
			error_q     <= '0;
			ok_q        <= 1'b0;
			kind_q      <= '0;
			file_q      <= '0;
			total_q     <= '0;
			seg_q       <= '0;
			bytes_q     <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				accepted_q <= 1'b0;
				unique case (item.cmd)
					CMD_START: begin
						ok_q    <= 1'b1;
						kind_q  <= item.kind;
						file_q  <= item.file;
						total_q <= item.total;
						seg_q   <= '0;
						bytes_q <= '0;
					end
					CMD_APPEND: begin
						first_q    <= 1'b0;
						expected_q <= item.seq + 32'd1;
						if (fwd) begin
							missed_q <= missed_add;
						end
						seg_q <= seg_next;
						ok_q  <= ok_next;
						if (ok_next) begin
							if (fits) begin
								bytes_q    <= sum[15:0];
								accepted_q <= 1'b1;
							end
						end else begin
							error_q <= error_q + 1'b1;
						end
					end
					CMD_CLEAR: begin
						first_q    <= 1'b1;
						expected_q <= '0;
						missed_q   <= '0;
						error_q    <= '0;
						bytes_q    <= '0;
					end
					CMD_NONE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/core/segment_reassembly_checker.sv
// Segment reassembly checker: one packet header word in, one status word out per header.
// The front stage decodes and registers each word, a short queue decouples it from the
// back stage, whose state update (sequence gap add, header compare and fill check against
// capacity) sets the rate of one header per cycle unless stalled. Each header passes the
// front register and a queue slot before its result is registered; either side may stall
// without stopping the other until the queue fills. capacity_q is written through wr_en
// and wr_data, resets to 4096, and must only change while no header is in flight.
module segment_reassembly_checker #(
	parameter int COUNT_WIDTH = srchk_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = srchk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] packet_sequence,
	input  logic [7:0]  packet_kind,
	input  logic [15:0] file_number,
	input  logic [15:0] segment_index,
	input  logic [15:0] segment_total,
	input  logic [15:0] payload_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [31:0] missed_count,
	output logic [31:0] error_count,
	output logic [15:0] fill_level
);
	import srchk_pkg::*;

	logic [15:0] capacity_q;
	q_status_t   q_stat;
	logic        push;
	logic        pop;
	item_t       push_item;
	item_t       pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (wr_en) begin
			capacity_q <= wr_data;
		end
	end

	srchk_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.packet_sequence (packet_sequence),
		.packet_kind     (packet_kind),
		.file_number     (file_number),
		.segment_index   (segment_index),
		.segment_total   (segment_total),
		.payload_length  (payload_length),
		.q_stat          (q_stat),
		.push            (push),
		.push_item       (push_item)
	);

	srchk_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	srchk_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.capacity     (capacity_q),
		.q_stat       (q_stat),
		.item         (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.missed_count (missed_count),
		.error_count  (error_count),
		.fill_level   (fill_level)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> fill_level <= capacity_q)
		else $error("accepted segment left fill level above capacity");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("result word offered with nothing queued");

	a_push_gate: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("word pushed into a full queue");

endmodule
